@@ rtl/core/spca_pkg.sv @@
// spca_pkg: shared constants, types and command/status structs for the
// sensor polynomial calibration block. No dependencies.
`default_nettype none
package spca_pkg;
  localparam int PolyOrder  = 4;
  localparam int NumSensors = 6;
  localparam int MaxScans   = 1024;
  localparam int NumRows    = 7;
  localparam int RowSlots   = 8;
  localparam int CntW       = $clog2(MaxScans + 1);
  localparam int TermW      = 3;
  localparam int AddrW      = 6;
  localparam int SumW       = 48;
  localparam logic [15:0] Missing = 16'hFFFF;

  // configuration register indexes
  localparam logic [0:0] CfgFixedSide = 1'b0;
  localparam logic [0:0] CfgFillValue = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_SCAN   = 2'd1,
    OP_FINISH = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam logic [2:0] RowBase [NumSensors] = '{3'd0, 3'd3, 3'd5, 3'd5, 3'd3, 3'd5};

  // controller -> datapath
  typedef struct packed {
    logic             latch_in;   // capture scan readings/flags
    logic             mem_we;     // coefficient write
    logic             mem_rd;     // issue coefficient read
    logic [2:0]       sensor;     // sensor being processed
    logic [TermW-1:0] term;       // term read address
    logic             h_init;     // t = coefficient
    logic             h_step;     // t = sat(sat(t*r) + coefficient)
    logic             acc;        // accumulate converted t
    logic             div_start;  // start average of sensor
    logic             div_step;   // one quotient bit
    logic             emit;       // load output register
    logic             clr;        // clear sensor accumulators
  } spca_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sensor_ok;  // sample for current sensor is taken
  } spca_sts_t;
endpackage
`default_nettype wire

@@ rtl/core/spca_ram.sv @@
// spca_ram: generic single-port write / single-port read RAM, registered read.
// No dependencies.
`default_nettype none
module spca_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/core/spca_datapath.sv @@
// spca_datapath: coefficient RAM, Horner unit, accumulators, serial divider
// and output register. Depends on spca_pkg and spca_ram.
`default_nettype none
module spca_datapath
  import spca_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire spca_cmd_t   cmd,
  output spca_sts_t        sts,
  input  wire logic [2:0]  in_coeff_row,
  input  wire logic [2:0]  in_coeff_term,
  input  wire logic [63:0] in_coeff_value,
  input  wire logic [3:0]  in_heater_flags,
  input  wire logic [15:0] in_reading_0,
  input  wire logic [15:0] in_reading_1,
  input  wire logic [15:0] in_reading_2,
  input  wire logic [15:0] in_reading_3,
  input  wire logic [15:0] in_reading_4,
  input  wire logic [15:0] in_reading_5,
  input  wire logic        fixed_side_mode,
  input  wire logic [31:0] fill_value,
  output logic [2:0]       out_sensor_index,
  output logic [31:0]      out_average_value,
  output logic             out_has_samples,
  output logic             out_last
);
  logic [15:0]     rd_r [NumSensors];
  logic [3:0]      flags_r;
  logic [SumW-1:0] sum_r [NumSensors];
  logic [CntW-1:0] cnt_r [NumSensors];
  logic [63:0]     t_r;
  logic [63:0]     rdata;
  logic [AddrW-1:0] waddr, raddr;
  logic [2:0]      row_sel;
  logic            row_ok;
  logic [1:0]      e0, e1;
  logic            ok0, ok1;
  logic [15:0]     r_cur;
  logic [63:0]     mag;
  logic            neg;
  logic [79:0]     prod;
  logic [63:0]     pm;
  logic [63:0]     mul_s;
  logic [64:0]     sum65;
  logic [63:0]     add_s;
  logic [63:0]     biased;
  logic [40:0]     q41;
  logic signed [40:0] v41;
  logic [31:0]     conv;
  // divider
  logic [SumW-1:0] dmag_r;
  logic [SumW:0]   rem_r;
  logic [SumW-1:0] quo_r;
  logic            dneg_r;
  logic [CntW-1:0] dn_r;
  logic [SumW:0]   rem_sh;
  logic [SumW-1:0] s_sum;
  logic            s_neg;
  logic [SumW-1:0] s_mag;
  logic [SumW-1:0] quo_nxt;
  logic [31:0]     q32;

  assign waddr = {in_coeff_row, in_coeff_term};

  always_comb begin
    e0 = 2'd0; ok0 = 1'b1;
    unique case (flags_r[3:2])
      2'b01:   e0 = 2'd0;
      2'b00:   e0 = 2'd1;
      2'b10:   e0 = 2'd2;
      default: ok0 = 1'b0;
    endcase
    e1 = 2'd0; ok1 = 1'b1;
    if (!fixed_side_mode) begin
      unique case (flags_r[1:0])
        2'b10:   e1 = 2'd0;
        2'b01:   e1 = 2'd1;
        default: ok1 = 1'b0;
      endcase
    end
    r_cur = rd_r[cmd.sensor];
    row_sel = RowBase[cmd.sensor] + ((cmd.sensor == 3'd0) ? {1'b0, e0} : {1'b0, e1});
    row_ok  = (cmd.sensor == 3'd0) ? ok0 : ok1;
    sts.sensor_ok = row_ok && (r_cur != Missing) && (cnt_r[cmd.sensor] < CntW'(MaxScans));
  end
  assign raddr = {row_sel, cmd.term};

  spca_ram #(.Width(64), .Depth(64)) u_ram (
    .clk  (clk),
    .we   (cmd.mem_we),
    .waddr(waddr),
    .wdata(in_coeff_value),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    neg  = t_r[63];
    mag  = neg ? (64'd0 - t_r) : t_r;
    prod = mag * {64'd0, r_cur};
    pm   = prod[63:0];
    if (prod[79:64] != 16'd0 || (neg ? (pm > 64'h8000_0000_0000_0000)
                                     : pm[63])) begin
      mul_s = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end else begin
      mul_s = neg ? (64'd0 - pm) : pm;
    end
    sum65 = {mul_s[63], mul_s} + {rdata[63], rdata};
    if (sum65[64] != sum65[63]) begin
      add_s = sum65[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end else begin
      add_s = sum65[63:0];
    end
    biased = t_r ^ 64'h8000_0000_0000_0000;
    q41 = {1'b0, biased[63:24]} + {40'd0, biased[23]};
    v41 = $signed(q41) - $signed({2'b01, 39'd0});
    if (v41 > 41'sd2147483647) begin
      conv = 32'h7FFF_FFFF;
    end else if (v41 < -41'sd2147483648) begin
      conv = 32'h8000_0000;
    end else begin
      conv = v41[31:0];
    end
  end

  always_comb begin
    s_sum  = sum_r[cmd.sensor];
    s_neg  = s_sum[SumW-1];
    s_mag  = s_neg ? (SumW'(0) - s_sum) : s_sum;
    rem_sh = {rem_r[SumW-1:0], dmag_r[SumW-1]};
    quo_nxt = {quo_r[SumW-2:0], 1'b0};
    if (rem_sh >= {{(SumW+1-CntW){1'b0}}, dn_r}) begin
      quo_nxt[0] = 1'b1;
    end
    q32 = dneg_r ? (32'd0 - quo_r[31:0]) : quo_r[31:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      rd_r[0] <= in_reading_0; rd_r[1] <= in_reading_1;
      rd_r[2] <= in_reading_2; rd_r[3] <= in_reading_3;
      rd_r[4] <= in_reading_4; rd_r[5] <= in_reading_5;
      flags_r <= in_heater_flags;
    end
    if (cmd.h_init) begin
      t_r <= rdata;
    end else if (cmd.h_step) begin
      t_r <= add_s;
    end
    if (cmd.div_start) begin
      dn_r   <= cnt_r[cmd.sensor];
      dneg_r <= s_neg;
      dmag_r <= s_mag + SumW'(cnt_r[cmd.sensor] >> 1);
      rem_r  <= '0;
      quo_r  <= '0;
    end else if (cmd.div_step) begin
      dmag_r <= {dmag_r[SumW-2:0], 1'b0};
      quo_r  <= quo_nxt;
      rem_r  <= quo_nxt[0] ? (rem_sh - {{(SumW+1-CntW){1'b0}}, dn_r}) : rem_sh;
    end
    if (cmd.emit) begin
      out_sensor_index  <= cmd.sensor;
      out_has_samples   <= (dn_r != '0);
      out_average_value <= (dn_r != '0) ? q32 : fill_value;
      out_last          <= (cmd.sensor == 3'(NumSensors - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumSensors; i++) begin
        sum_r[i] <= '0;
        cnt_r[i] <= '0;
      end
    end else if (cmd.acc) begin
      sum_r[cmd.sensor] <= sum_r[cmd.sensor] + {{(SumW-32){conv[31]}}, conv};
      cnt_r[cmd.sensor] <= cnt_r[cmd.sensor] + 1'b1;
    end else if (cmd.clr) begin
      sum_r[cmd.sensor] <= '0;
      cnt_r[cmd.sensor] <= '0;
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/spca_ctrl.sv @@
// spca_ctrl: sequencer for load, scan (Horner per sensor) and finish (divide
// per sensor, emit). Depends on spca_pkg.
`default_nettype none
module spca_ctrl
  import spca_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_op,
  input  wire logic [2:0] in_coeff_row,
  output logic            out_valid,
  input  wire logic       out_ready,
  output spca_cmd_t       cmd,
  input  wire spca_sts_t  sts
);
  typedef enum logic [2:0] {
    S_IDLE, S_SEL, S_INIT, S_STEP, S_ACC, S_DIV, S_OUT
  } state_t;

  state_t           state_r, state_nxt;
  logic [2:0]       sensor_r, sensor_nxt;
  logic [TermW-1:0] term_r, term_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             ov_r, ov_nxt;
  logic             acc_in;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;
  assign acc_in    = in_valid && in_ready;

  always_comb begin
    state_nxt  = state_r;
    sensor_nxt = sensor_r;
    term_nxt   = term_r;
    cnt_nxt    = cnt_r;
    ov_nxt     = ov_r;
    cmd        = '0;
    cmd.sensor = sensor_r;
    cmd.term   = term_r;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (acc_in) begin
          unique case (op_t'(in_op))
            OP_LOAD:   cmd.mem_we = (in_coeff_row < 3'(NumRows));
            OP_SCAN: begin
              cmd.latch_in = 1'b1;
              sensor_nxt = '0;
              state_nxt  = S_SEL;
            end
            OP_FINISH: begin
              sensor_nxt = '0;
              state_nxt  = S_DIV;
              cmd.sensor = '0;
              cmd.div_start = 1'b1;
              cnt_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      S_SEL: begin
        term_nxt = TermW'(PolyOrder - 1);
        cmd.term = TermW'(PolyOrder - 1);
        if (sts.sensor_ok) begin
          state_nxt = S_INIT;
        end else if (sensor_r == 3'(NumSensors - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          sensor_nxt = sensor_r + 3'd1;
        end
      end
      S_INIT: begin
        cmd.h_init = 1'b1;
        if (PolyOrder == 1) begin
          state_nxt = S_ACC;
        end else begin
          term_nxt = term_r - 1'b1;
          cmd.term = term_r - 1'b1;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        cmd.h_step = 1'b1;
        if (term_r == '0) begin
          state_nxt = S_ACC;
        end else begin
          term_nxt = term_r - 1'b1;
          cmd.term = term_r - 1'b1;
        end
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (sensor_r == 3'(NumSensors - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          sensor_nxt = sensor_r + 3'd1;
          state_nxt  = S_SEL;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(SumW - 1)) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_r || out_ready) begin
          cmd.emit = 1'b1;
          cmd.clr  = 1'b1;
          ov_nxt   = 1'b1;
          if (sensor_r == 3'(NumSensors - 1)) begin
            state_nxt = S_IDLE;
          end else begin
            sensor_nxt = sensor_r + 3'd1;
            state_nxt  = S_DIV;
            // first S_DIV cycle is the divider start, count wraps to 0 after it
            cnt_nxt    = '1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      sensor_r <= '0;
      term_r   <= '0;
      cnt_r    <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      sensor_r <= sensor_nxt;
      term_r   <= term_nxt;
      cnt_r    <= cnt_nxt;
      ov_r     <= ov_nxt;
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/spca_start.sv @@
// spca_start: issues the divider start for sensors after the first in a
// finish transaction. Depends on spca_pkg.
`default_nettype none
module spca_start
  import spca_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire spca_cmd_t cmd_in,
  output spca_cmd_t      cmd_out
);
  logic pend_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= cmd_in.emit && (cmd_in.sensor != 3'(NumSensors - 1));
    end
  end
  always_comb begin
    cmd_out = cmd_in;
    if (pend_r) begin
      cmd_out.div_start = 1'b1;
      cmd_out.div_step  = 1'b0;
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/sensor_poly_calibrate_average.sv @@
// sensor_poly_calibrate_average: top level; controller plus datapath.
// Depends on spca_pkg, spca_ctrl, spca_start, spca_datapath.
//
// channel | signals                         | direction
// cfg     | cfg_valid/ready, index, data    | in
// in      | in_valid/ready, op, fields      | in
// out     | out_valid/ready, index, average | out
//
// Scan: one shared Horner multiplier and the coefficient RAM read port serve the
// sensors in turn. Finish: six averages, each a start, 48 bit-serial divider
// steps and an emit. Synchronous active-low reset. Output held in a register;
// a stalled output pauses the finish sequence.
`default_nettype none
module sensor_poly_calibrate_average
  import spca_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_op,
  input  wire logic [2:0]  in_coeff_row,
  input  wire logic [2:0]  in_coeff_term,
  input  wire logic [63:0] in_coeff_value,
  input  wire logic [3:0]  in_heater_flags,
  input  wire logic [15:0] in_reading_0,
  input  wire logic [15:0] in_reading_1,
  input  wire logic [15:0] in_reading_2,
  input  wire logic [15:0] in_reading_3,
  input  wire logic [15:0] in_reading_4,
  input  wire logic [15:0] in_reading_5,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_sensor_index,
  output logic [31:0]      out_average_value,
  output logic             out_has_samples,
  output logic             out_last
);
  logic        fixed_side_mode_r;
  logic [31:0] fill_value_r;
  spca_cmd_t   cmd_c, cmd;
  spca_sts_t   sts;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fixed_side_mode_r <= 1'b0;
      fill_value_r      <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CfgFixedSide) begin
        fixed_side_mode_r <= cfg_data[0];
      end else begin
        fill_value_r <= cfg_data;
      end
    end
  end

  spca_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_op(in_op), .in_coeff_row(in_coeff_row), .out_valid(out_valid),
    .out_ready(out_ready), .cmd(cmd_c), .sts(sts)
  );

  spca_start u_start (.clk(clk), .rst_n(rst_n), .cmd_in(cmd_c), .cmd_out(cmd));

  spca_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_coeff_row(in_coeff_row), .in_coeff_term(in_coeff_term),
    .in_coeff_value(in_coeff_value), .in_heater_flags(in_heater_flags),
    .in_reading_0(in_reading_0), .in_reading_1(in_reading_1),
    .in_reading_2(in_reading_2), .in_reading_3(in_reading_3),
    .in_reading_4(in_reading_4), .in_reading_5(in_reading_5),
    .fixed_side_mode(fixed_side_mode_r), .fill_value(fill_value_r),
    .out_sensor_index(out_sensor_index), .out_average_value(out_average_value),
    .out_has_samples(out_has_samples), .out_last(out_last)
  );
endmodule
`default_nettype wire

@@ test/tb_sensor_poly_calibrate_average.sv @@
// Testbench for sensor_poly_calibrate_average: coefficient loads, scans and finishes
// checked against an in-bench fixed-point predictor. Depends on spca_pkg and the RTL.
module tb_sensor_poly_calibrate_average
  import spca_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  row;
    logic [2:0]  term;
    logic [63:0] value;
    logic [3:0]  flags;
    logic [15:0] rd0, rd1, rd2, rd3, rd4, rd5;
  } scan_item_t;

  typedef struct packed {
    logic [2:0]  idx;
    logic [31:0] avg;
    logic        has;
    logic        last;
  } avg_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0, in_ready;
  logic in_acc = 1'b0;
  scan_item_t cur = '0;
  logic out_valid, out_ready = 1'b0;
  logic [2:0] out_sensor_index;
  logic [31:0] out_average_value;
  logic out_has_samples, out_last;

  sensor_poly_calibrate_average u_top (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_op(cur.op), .in_coeff_row(cur.row),
    .in_coeff_term(cur.term), .in_coeff_value(cur.value),
    .in_heater_flags(cur.flags), .in_reading_0(cur.rd0), .in_reading_1(cur.rd1),
    .in_reading_2(cur.rd2), .in_reading_3(cur.rd3), .in_reading_4(cur.rd4),
    .in_reading_5(cur.rd5), .out_valid, .out_ready, .out_sensor_index,
    .out_average_value, .out_has_samples, .out_last
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #10ms;
    $display("simulation failed");
    $finish;
  end

  // predictor state
  logic [63:0] coeff_tab [NumRows*RowSlots];
  logic signed [63:0] temp_sum [NumSensors];
  int unsigned temp_cnt [NumSensors];
  logic side_fixed;
  logic [31:0] fill_word;

  scan_item_t pending_q[$];
  avg_result_t avg_expect_q[$];
  int errors = 0, n_results = 0, n_scans = 0, n_finish = 0;
  bit hold_off = 0;

  localparam logic signed [63:0] SMax = 64'sh7FFFFFFFFFFFFFFF;
  localparam logic signed [63:0] SMin = 64'sh8000000000000000;

  function automatic logic signed [63:0] mul_sat(logic signed [63:0] t, logic [15:0] r);
    logic signed [81:0] p;
    p = t * $signed({1'b0, r});
    if (p > SMax) return SMax;
    if (p < SMin) return SMin;
    return p[63:0];
  endfunction

  function automatic logic signed [63:0] add_sat(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = a + b;
    if (s > SMax) return SMax;
    if (s < SMin) return SMin;
    return s[63:0];
  endfunction

  function automatic logic signed [31:0] q40_round(logic signed [63:0] x);
    logic signed [64:0] v;
    v = ($signed({x[63], x}) + 65'sd8388608) >>> 24;
    if (v > 65'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -65'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  task automatic take_sample(int s, int row, logic [15:0] r);
    logic signed [63:0] t;
    if (r == Missing || temp_cnt[s] >= MaxScans) return;
    t = coeff_tab[row*RowSlots + PolyOrder - 1];
    for (int k = PolyOrder - 2; k >= 0; k--)
      t = add_sat(mul_sat(t, r), coeff_tab[row*RowSlots + k]);
    temp_sum[s] += q40_round(t);
    temp_cnt[s]++;
  endtask

  task automatic predict(scan_item_t it);
    logic [15:0] rd [NumSensors];
    int e;
    logic signed [63:0] mag;
    logic [63:0] q;
    avg_result_t res;
    rd = '{it.rd0, it.rd1, it.rd2, it.rd3, it.rd4, it.rd5};
    case (op_t'(it.op))
      OP_LOAD: if (it.row < NumRows) coeff_tab[it.row*RowSlots + it.term] = it.value;
      OP_SCAN: begin
        n_scans++;
        case (it.flags[3:2])
          2'b01: e = 0;
          2'b00: e = 1;
          2'b10: e = 2;
          default: e = -1;
        endcase
        if (e >= 0) take_sample(0, RowBase[0] + e, rd[0]);
        if (side_fixed) e = 0;
        else if (it.flags[1:0] == 2'b10) e = 0;
        else if (it.flags[1:0] == 2'b01) e = 1;
        else e = -1;
        if (e >= 0)
          for (int s = 1; s < NumSensors; s++) take_sample(s, RowBase[s] + e, rd[s]);
      end
      OP_FINISH: begin
        n_finish++;
        for (int s = 0; s < NumSensors; s++) begin
          res.idx = 3'(s);
          res.has = temp_cnt[s] > 0;
          res.last = s == NumSensors - 1;
          res.avg = fill_word;
          if (temp_cnt[s] > 0) begin
            mag = temp_sum[s] < 0 ? -temp_sum[s] : temp_sum[s];
            q = (mag + temp_cnt[s] / 2) / temp_cnt[s];
            res.avg = temp_sum[s] < 0 ? -q[31:0] : q[31:0];
          end
          avg_expect_q.push_back(res);
          temp_sum[s] = 0;
          temp_cnt[s] = 0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("MISMATCH %s: got %0h want %0h (result %0d)", what, got, want, n_results);
  endtask

  // input transaction seen at the last rising edge
  always @(posedge clk) in_acc <= in_valid && in_ready;

  // driver: bursts and gaps
  int gap = 0, burst = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_acc) predict(cur);
      if (!in_valid || in_acc) begin
        if (gap > 0) begin
          gap--;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          cur <= pending_q.pop_front();
          in_valid <= 1'b1;
          if (burst == 0) begin
            burst = $urandom_range(1, 12);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
          end else burst--;
        end else in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern
  int stall_mode = 0;
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready <= !hold_off;
      1: out_ready <= !hold_off && $urandom_range(0, 3) != 0;
      default: out_ready <= !hold_off && $urandom_range(0, 5) == 0;
    endcase
  end

  // monitor
  always @(posedge clk) begin
    avg_result_t w;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (avg_expect_q.size() == 0) begin
        report("unexpected result", 64'(out_sensor_index), 64'd0);
      end else begin
        w = avg_expect_q.pop_front();
        if (out_sensor_index !== w.idx)
          report("sensor_index", 64'(out_sensor_index), 64'(w.idx));
        if (out_average_value !== w.avg)
          report("average_value", 64'(out_average_value), 64'(w.avg));
        if (out_has_samples !== w.has)
          report("has_samples", 64'(out_has_samples), 64'(w.has));
        if (out_last !== w.last) report("last", 64'(out_last), 64'(w.last));
      end
    end
  end

  function automatic logic [15:0] rand_reading();
    case ($urandom_range(0, 9))
      0: return Missing;
      1: return 16'h0000;
      2: return 16'hFFFE;
      3: return 16'($urandom);
      default: return 16'($urandom_range(0, 4000));
    endcase
  endfunction

  function automatic scan_item_t mk_load(int row, int term, logic [63:0] v);
    scan_item_t it;
    it = '0;
    it.op = OP_LOAD; it.row = 3'(row); it.term = 3'(term); it.value = v;
    it.flags = 4'($urandom); it.rd0 = 16'($urandom); it.rd1 = 16'($urandom);
    return it;
  endfunction

  function automatic scan_item_t mk_scan(logic [3:0] f);
    scan_item_t it;
    it.op = OP_SCAN; it.row = 3'($urandom); it.term = 3'($urandom);
    it.value = {$urandom, $urandom};
    it.flags = f;
    it.rd0 = rand_reading(); it.rd1 = rand_reading(); it.rd2 = rand_reading();
    it.rd3 = rand_reading(); it.rd4 = rand_reading(); it.rd5 = rand_reading();
    return it;
  endfunction

  function automatic scan_item_t mk_op(op_t op);
    scan_item_t it;
    it = mk_scan(4'($urandom));
    it.op = op;
    return it;
  endfunction

  // small coefficients keep temperatures in range; a few huge ones exercise saturation
  function automatic logic [63:0] rand_coeff(int term);
    logic signed [63:0] c;
    case ($urandom_range(0, 11))
      0: return 64'h7FFFFFFFFFFFFFFF;
      1: return 64'h8000000000000000;
      2: return {$urandom, $urandom};
      default: begin
        c = $signed({$urandom, $urandom}) >>> (24 + 14 * term);
        return c;
      end
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_q.size() > 0 || in_valid || avg_expect_q.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CfgFixedSide) side_fixed = d[0]; else fill_word = d;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_table(bit extreme);
    for (int r = 0; r < NumRows; r++)
      for (int t = 0; t < RowSlots; t++)
        pending_q.push_back(mk_load(r, t, extreme ? (t[0] ? 64'h8000000000000000 :
                                                    64'h7FFFFFFFFFFFFFFF) : rand_coeff(t)));
  endtask

  task automatic random_phase(int n);
    scan_item_t it;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0: pending_q.push_back(mk_op(OP_FINISH));
        1: pending_q.push_back(mk_op(OP_NONE));
        2: begin
          it = mk_load($urandom_range(0, 7), $urandom_range(0, 7),
                       rand_coeff($urandom_range(0, 3)));
          pending_q.push_back(it);
        end
        3, 4: pending_q.push_back(mk_scan(4'($urandom)));
        default: pending_q.push_back(mk_scan({$urandom_range(0, 1) ? 2'b01 : 2'b10,
                                              $urandom_range(0, 1) ? 2'b01 : 2'b10}));
      endcase
    end
    pending_q.push_back(mk_op(OP_FINISH));
  endtask

  initial begin
    scan_item_t it;
    foreach (coeff_tab[i]) coeff_tab[i] = '0;
    foreach (temp_sum[i]) begin temp_sum[i] = 0; temp_cnt[i] = 0; end
    side_fixed = 1'b0;
    fill_word = '0;
    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: full table at extremes, then flag cases and edge readings
    write_reg(CfgFillValue, 32'h80000000);
    load_table(1'b1);
    pending_q.push_back(mk_load(7, 3, 64'h1234));
    for (int f = 0; f < 16; f += 5) begin
      it = mk_scan(f[3:0]);
      it.rd0 = 16'h0000; it.rd1 = 16'hFFFE; it.rd2 = Missing;
      pending_q.push_back(it);
    end
    pending_q.push_back(mk_op(OP_NONE));
    pending_q.push_back(mk_op(OP_FINISH));
    pending_q.push_back(mk_op(OP_FINISH));
    wait_drained();

    load_table(1'b0);
    wait_drained();

    // random phases across register settings
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CfgFixedSide, {31'd0, ph[0]});
      write_reg(CfgFillValue, ph == 2 ? 32'h7FFFFFFF : $urandom);
      if (ph == 1) begin
        hold_off = 1;
        pending_q.push_back(mk_op(OP_FINISH));
      end
      random_phase(45);
      if (ph == 1) begin
        while (!(out_valid && !in_ready)) @(posedge clk);
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      wait_drained();
    end

    $display("covered %0d scans, %0d finishes, %0d averages checked",
             n_scans, n_finish, n_results);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
